>>> rtl/rpn_stack_calculator_defines.svh
// Assertion macros for the RPN stack calculator.
// Every macro expects signals named clk and rst_n in the module that uses it.
`ifndef RPN_STACK_CALCULATOR_DEFINES_SVH
`define RPN_STACK_CALCULATOR_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define RSC_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("rsc: invariant violated");

// Consequence that must hold in the same cycle as the antecedent
`define RSC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rsc: implication violated");

// Consequence that must hold in the cycle after the antecedent
`define RSC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rsc: next-cycle implication violated");

`endif

>>> rtl/rsc_pkg.sv
// Shared constants, codes and the token command type of the RPN calculator.
// No dependencies; every other RTL file but the macros header imports it.
`timescale 1ns / 1ps
`default_nettype none

package rsc_pkg;

  // Defaults for the top-level parameters
  localparam int STACK_DEPTH_DEF = 32;
  localparam int VALUE_WIDTH_DEF = 32;

  // Command queue between front and back
  localparam int FIFO_DEPTH = 4;

  // Fixed field widths
  localparam int CH_W     = 8;
  localparam int OUT_W    = 32;
  localparam int STATUS_W = 3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_TOKEN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FEW       = 3'd2;
  localparam logic [STATUS_W-1:0] ST_DIV0      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MANY      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 3'd5;

  // Token kinds carried in a command
  localparam logic [1:0] K_NONE  = 2'd0;
  localparam logic [1:0] K_DIGIT = 2'd1;
  localparam logic [1:0] K_OP    = 2'd2;
  localparam logic [1:0] K_BAD   = 2'd3;

  // Operator codes
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Characters of interest
  localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_W-1:0] CH_CR    = 8'h0D;

  // One finished token, optionally flagged as the end of the expression
  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] arg;   // digit value, or operator code in the low bits
    logic       last;
  } rsc_cmd_t;

endpackage

`default_nettype wire

>>> rtl/rsc_stream_if.sv
// Valid/ready stream interfaces for the character input and the result output.
// Depends on rsc_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface rsc_in_if;
  import rsc_pkg::*;
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;
  modport source (output valid, ch, last, input ready);
  modport sink   (input valid, ch, last, output ready);
endinterface

interface rsc_out_if;
  import rsc_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [OUT_W-1:0]    value;
  logic        [STATUS_W-1:0] status;
  modport source (output valid, value, status, input ready);
  modport sink   (input valid, value, status, output ready);
endinterface

`default_nettype wire

>>> rtl/rsc_front.sv
// Tokeniser: takes one character a beat and emits finished tokens as commands.
// Depends on rsc_pkg and rsc_in_if.
`timescale 1ns / 1ps
`default_nettype none

module rsc_front (
  input  logic                clk,
  input  logic                rst_n,
  rsc_in_if.sink              in_ch,
  output rsc_pkg::rsc_cmd_t   cmd,
  output logic                cmd_we,
  input  logic                cmd_full
);
  import rsc_pkg::*;

  // Token length codes
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_ONE  = 2'd1;
  localparam logic [1:0] LEN_MANY = 2'd2;

  logic [1:0]      len_r, len_nxt;
  logic [CH_W-1:0] first_r, first_nxt;
  logic [1:0]      fin_len;
  logic [CH_W-1:0] fin_char;
  logic [CH_W-1:0] digit_val;
  logic            is_space;
  logic            accept;

  assign in_ch.ready = !cmd_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign digit_val   = fin_char - CH_ZERO;

  // Track the pending token and pick out the one that finishes on this beat
  always_comb begin
    is_space  = (in_ch.ch == CH_SPACE) || (in_ch.ch >= CH_TAB && in_ch.ch <= CH_CR);
    len_nxt   = len_r;
    first_nxt = first_r;
    fin_len   = LEN_NONE;
    fin_char  = first_r;
    if (is_space) begin
      fin_len   = len_r;
      len_nxt   = LEN_NONE;
      first_nxt = '0;
    end else begin
      if (len_r == LEN_NONE) first_nxt = in_ch.ch;
      if (len_r != LEN_MANY) len_nxt = len_r + 2'd1;
      if (in_ch.last) begin
        fin_len  = len_nxt;
        fin_char = first_nxt;
      end
    end
    if (in_ch.last) begin
      len_nxt   = LEN_NONE;
      first_nxt = '0;
    end
  end

  // Classify the finished token
  always_comb begin
    cmd.last = in_ch.last;
    cmd.arg  = '0;
    if (fin_len == LEN_NONE) begin
      cmd.kind = K_NONE;
    end else if (fin_len != LEN_ONE) begin
      cmd.kind = K_BAD;
    end else if (fin_char >= CH_ZERO && fin_char <= CH_NINE) begin
      cmd.kind = K_DIGIT;
      cmd.arg  = digit_val[3:0];
    end else begin
      unique case (fin_char)
        CH_PLUS: begin
          cmd.kind = K_OP;
          cmd.arg  = {2'b00, OP_ADD};
        end
        CH_MINUS: begin
          cmd.kind = K_OP;
          cmd.arg  = {2'b00, OP_SUB};
        end
        CH_STAR: begin
          cmd.kind = K_OP;
          cmd.arg  = {2'b00, OP_MUL};
        end
        CH_SLASH: begin
          cmd.kind = K_OP;
          cmd.arg  = {2'b00, OP_DIV};
        end
        default: cmd.kind = K_BAD;
      endcase
    end
  end

  assign cmd_we = accept && ((fin_len != LEN_NONE) || in_ch.last);

  // Hold token state between beats
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_NONE;
      first_r <= '0;
    end else if (accept) begin
      len_r   <= len_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/rsc_fifo.sv
// Short command queue between the tokeniser and the evaluator.
// Depends on rsc_pkg for the command type and depth.
`timescale 1ns / 1ps
`default_nettype none

module rsc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  rsc_pkg::rsc_cmd_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output rsc_pkg::rsc_cmd_t rd_data,
  output logic              empty
);
  import rsc_pkg::*;
  `include "rpn_stack_calculator_defines.svh"

  localparam int PW = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CW = $clog2(FIFO_DEPTH + 1);

  rsc_cmd_t        slot_r [FIFO_DEPTH];
  logic [PW-1:0]   wptr_r, rptr_r;
  logic [CW-1:0]   cnt_r;
  logic            do_wr, do_rd;

  assign full    = (cnt_r == CW'(FIFO_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slot_r[rptr_r];

  // Store the command
  always_ff @(posedge clk) begin
    if (do_wr) slot_r[wptr_r] <= wr_data;
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) wptr_r <= (wptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      if (do_rd) rptr_r <= (rptr_r == PW'(FIFO_DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      if (do_wr && !do_rd) cnt_r <= cnt_r + CW'(1);
      else if (do_rd && !do_wr) cnt_r <= cnt_r - CW'(1);
    end
  end

  `RSC_ASSERT_ALWAYS(a_fifo_bound, cnt_r <= CW'(FIFO_DEPTH))

endmodule

`default_nettype wire

>>> rtl/rsc_back.sv
// Evaluator: executes token commands on the operand stack and delivers results.
// Depends on rsc_pkg, rsc_out_if and the assertion macros header.
`timescale 1ns / 1ps
`default_nettype none

module rsc_back #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = rsc_pkg::VALUE_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  rsc_pkg::rsc_cmd_t cmd,
  input  logic              cmd_empty,
  output logic              cmd_rd,
  rsc_out_if.source         out_ch
);
  import rsc_pkg::*;
  `include "rpn_stack_calculator_defines.svh"

  localparam int VW        = VALUE_WIDTH;
  localparam int CW        = $clog2(STACK_DEPTH + 1);
  localparam int MEM_DEPTH = STACK_DEPTH - 1;
  localparam int AW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int SW        = $clog2(VALUE_WIDTH);

  // Sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_ITER = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_END  = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic [VW-1:0]       tos_r, tos_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;
  logic                last_r, last_nxt;
  logic [1:0]          op_r, op_nxt;
  logic [VW-1:0]       x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic                neg_r, neg_nxt;
  logic [SW-1:0]       step_r, step_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_value_r, out_value_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  // Entries below the top of stack; the top lives in tos_r
  logic [VW-1:0]       mem [MEM_DEPTH];
  logic [VW-1:0]       rd_q;
  logic                mem_we;
  logic [CW-1:0]       cnt_m1, cnt_m2;
  logic [AW-1:0]       wr_addr, rd_addr;

  logic [2:0]          after_cmd, after_last;
  logic                slot_free;
  logic [VW:0]         rem_sh, diff;
  logic                qbit;
  logic [63:0]         tos_ext;
  logic [STATUS_W-1:0] fin_status;

  assign cnt_m1     = cnt_r - CW'(1);
  assign cnt_m2     = cnt_r - CW'(2);
  assign wr_addr    = cnt_m1[AW-1:0];
  assign rd_addr    = cnt_m2[AW-1:0];
  assign after_cmd  = cmd.last ? S_END : S_IDLE;
  assign after_last = last_r ? S_END : S_IDLE;
  assign slot_free  = !out_valid_r || out_ch.ready;
  assign tos_ext    = 64'(tos_r);

  // Restoring division step: shift in the next dividend bit, try the subtract
  assign rem_sh = {x_r, y_r[VW-1]};
  assign diff   = rem_sh - {1'b0, z_r};
  assign qbit   = !diff[VW];

  always_comb begin
    if (err_r != ST_OK)      fin_status = err_r;
    else if (cnt_r != CW'(1)) fin_status = ST_MANY;
    else                      fin_status = ST_OK;
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    tos_nxt        = tos_r;
    err_nxt        = err_r;
    last_nxt       = last_r;
    op_nxt         = op_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    z_nxt          = z_r;
    neg_nxt        = neg_r;
    step_nxt       = step_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    cmd_rd         = 1'b0;
    mem_we         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!cmd_empty) begin
          cmd_rd    = 1'b1;
          last_nxt  = cmd.last;
          state_nxt = after_cmd;
          if (err_r == ST_OK) begin
            unique case (cmd.kind)
              K_NONE: ;
              K_BAD: err_nxt = ST_BAD_TOKEN;
              K_DIGIT: begin
                if (cnt_r >= CW'(STACK_DEPTH)) begin
                  err_nxt = ST_OVERFLOW;
                end else begin
                  // Spill the old top and load the digit
                  mem_we  = (cnt_r != '0);
                  tos_nxt = VW'(cmd.arg);
                  cnt_nxt = cnt_r + CW'(1);
                end
              end
              K_OP: begin
                if (cnt_r < CW'(2)) begin
                  err_nxt = ST_FEW;
                end else begin
                  op_nxt    = cmd.arg[1:0];
                  state_nxt = S_READ;
                end
              end
              default: ;
            endcase
          end
        end
      end

      S_READ: begin
        // rd_q holds the second popped (left operand), tos_r the first popped
        unique case (op_r)
          OP_ADD: begin
            tos_nxt   = rd_q + tos_r;
            cnt_nxt   = cnt_m1;
            state_nxt = after_last;
          end
          OP_SUB: begin
            tos_nxt   = rd_q - tos_r;
            cnt_nxt   = cnt_m1;
            state_nxt = after_last;
          end
          OP_MUL: begin
            x_nxt     = '0;
            y_nxt     = rd_q;
            z_nxt     = tos_r;
            neg_nxt   = 1'b0;
            step_nxt  = '0;
            state_nxt = S_ITER;
          end
          OP_DIV: begin
            if (tos_r == '0) begin
              err_nxt   = ST_DIV0;
              state_nxt = after_last;
            end else begin
              x_nxt     = '0;
              y_nxt     = rd_q[VW-1] ? -rd_q : rd_q;
              z_nxt     = tos_r[VW-1] ? -tos_r : tos_r;
              neg_nxt   = rd_q[VW-1] ^ tos_r[VW-1];
              step_nxt  = '0;
              state_nxt = S_ITER;
            end
          end
          default: ;
        endcase
      end

      S_ITER: begin
        // One bit a cycle: shift-add multiply or restoring divide
        if (op_r == OP_MUL) begin
          if (z_r[0]) x_nxt = x_r + y_r;
          y_nxt = {y_r[VW-2:0], 1'b0};
          z_nxt = {1'b0, z_r[VW-1:1]};
        end else begin
          x_nxt = qbit ? diff[VW-1:0] : rem_sh[VW-1:0];
          y_nxt = {y_r[VW-2:0], qbit};
        end
        if (step_r == SW'(VALUE_WIDTH - 1)) begin
          step_nxt  = '0;
          state_nxt = S_FIX;
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end

      S_FIX: begin
        if (op_r == OP_MUL) tos_nxt = x_r;
        else                tos_nxt = neg_r ? -y_r : y_r;
        cnt_nxt   = cnt_m1;
        state_nxt = after_last;
      end

      S_END: begin
        // Deliver the result and clear the stack for the next expression
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = fin_status;
          out_value_nxt  = (fin_status == ST_OK) ? tos_ext[OUT_W-1:0] : '0;
          cnt_nxt        = '0;
          err_nxt        = ST_OK;
          state_nxt      = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // Stack memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[wr_addr] <= tos_r;
    rd_q <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      err_r       <= ST_OK;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    tos_r        <= tos_nxt;
    last_r       <= last_nxt;
    op_r         <= op_nxt;
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    z_r          <= z_nxt;
    neg_r        <= neg_nxt;
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.value  = out_value_r;
  assign out_ch.status = out_status_r;

  `RSC_ASSERT_ALWAYS(a_cnt_bound, cnt_r <= CW'(STACK_DEPTH))
  `RSC_ASSERT_IMP(a_step_idle, state_r != S_ITER, step_r == '0)
  `RSC_ASSERT_NXT(a_end_clears, (state_r == S_END) && slot_free, (cnt_r == '0) && (err_r == ST_OK) && out_valid_r)

endmodule

`default_nettype wire

>>> rtl/rpn_stack_calculator.sv
// RPN stack calculator: characters enter one a beat on in_ch; the beat flagged
// last yields one result on out_ch. The tokeniser takes a character every cycle
// while its four-entry command queue has room. The evaluator takes a digit in
// its idle state; + and - (and a division by zero) also pass through a read
// state, and * or / go on from it through an iterate state on a shared
// one-bit-a-cycle shift-add / restoring-divide unit and then a fix-up state.
// The end of an expression passes through an end state that loads the output
// register, and stays there while the previous result still waits on out_ch.
// Over long expressions the operator mix in the evaluator sets the throughput.
// Depends on rsc_pkg, rsc_stream_if, rsc_front, rsc_fifo and rsc_back.
`timescale 1ns / 1ps
`default_nettype none

module rpn_stack_calculator #(
  parameter int STACK_DEPTH = rsc_pkg::STACK_DEPTH_DEF,
  parameter int VALUE_WIDTH = rsc_pkg::VALUE_WIDTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rsc_in_if.sink     in_ch,
  rsc_out_if.source  out_ch
);
  import rsc_pkg::*;

  rsc_cmd_t wr_cmd, rd_cmd;
  logic     cmd_we, cmd_full, cmd_rd, cmd_empty;

  // Tokenise incoming characters
  rsc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .cmd      (wr_cmd),
    .cmd_we   (cmd_we),
    .cmd_full (cmd_full)
  );

  // Decouple tokeniser from evaluator
  rsc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_we),
    .wr_data (wr_cmd),
    .full    (cmd_full),
    .rd_en   (cmd_rd),
    .rd_data (rd_cmd),
    .empty   (cmd_empty)
  );

  // Evaluate tokens on the stack
  rsc_back #(
    .STACK_DEPTH (STACK_DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (rd_cmd),
    .cmd_empty (cmd_empty),
    .cmd_rd    (cmd_rd),
    .out_ch    (out_ch)
  );

endmodule

`default_nettype wire
